// ===== sv/ecfc_pkg.sv =====
// ecfc_pkg: shared types and constants of the e2e counter freshness checker
// used by ecfc_csr, ecfc_ctrl, ecfc_datapath and the top level
`default_nettype none

package ecfc_pkg;

   localparam int unsigned DATA_ID_W = 8;
   localparam int unsigned RX_ID_W   = 16;
   localparam int unsigned CRC_W     = 32;
   localparam int unsigned CNT_W     = 32;
   localparam int unsigned FRESH_W   = 16;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned ID_SPAN   = 1 << DATA_ID_W;

   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [1:0]           crc_mode_type;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_INVALID = 2'd1;
   localparam status_type STATUS_STALE   = 2'd2;

   localparam csr_index_type CSR_CRC_ENABLE        = 3'd0;
   localparam csr_index_type CSR_CRC_WIDTH_MODE    = 3'd1;
   localparam csr_index_type CSR_COUNTER_ENABLE    = 3'd2;
   localparam csr_index_type CSR_MAX_COUNTER       = 3'd3;
   localparam csr_index_type CSR_FRESHNESS_ENABLE  = 3'd4;
   localparam csr_index_type CSR_FRESHNESS_TIMEOUT = 3'd5;

   localparam crc_mode_type CRC_MODE_8  = 2'd0;
   localparam crc_mode_type CRC_MODE_16 = 2'd1;

   localparam logic FUNC_PROTECT  = 1'b0;
   localparam logic FUNC_VALIDATE = 1'b1;

   localparam logic [CNT_W-1:0]   ROLL_WINDOW   = 32'd10;
   localparam logic [CNT_W-1:0]   COUNTER_ONE   = 32'd1;
   localparam logic [CRC_W-1:0]   CRC_MASK_8    = 32'h0000_00FF;
   localparam logic [CRC_W-1:0]   CRC_MASK_16   = 32'h0000_FFFF;
   localparam logic [FRESH_W-1:0] FRESH_ALL_ONE = 16'hFFFF;

   localparam logic [CNT_W-1:0]   MAX_COUNTER_RESET = 32'd65535;
   localparam logic [FRESH_W-1:0] TIMEOUT_RESET     = 16'd1000;

   typedef struct packed {
      logic               crc_enable;
      crc_mode_type       crc_width_mode;
      logic               counter_enable;
      logic [CNT_W-1:0]   max_counter;
      logic               freshness_enable;
      logic [FRESH_W-1:0] freshness_timeout;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic mem_read;
      logic eval;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/ecfc_csr.sv =====
// ecfc_csr: configuration registers of the checker, write only
// depends on ecfc_pkg
`default_nettype none

module ecfc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire ecfc_pkg::csr_index_type         csr_index,
   input  wire logic [ecfc_pkg::CSR_DATA_W-1:0] csr_write_data,
   output ecfc_pkg::cfg_type                    cfg
);
   import ecfc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CRC_ENABLE:        cfg_in.crc_enable        = csr_write_data[0];
            CSR_CRC_WIDTH_MODE:    cfg_in.crc_width_mode    = csr_write_data[1:0];
            CSR_COUNTER_ENABLE:    cfg_in.counter_enable    = csr_write_data[0];
            CSR_MAX_COUNTER:       cfg_in.max_counter       = csr_write_data[CNT_W-1:0];
            CSR_FRESHNESS_ENABLE:  cfg_in.freshness_enable  = csr_write_data[0];
            CSR_FRESHNESS_TIMEOUT: cfg_in.freshness_timeout = csr_write_data[FRESH_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_enable        <= 1'b1;
         cfg_ff.crc_width_mode    <= CRC_MODE_8;
         cfg_ff.counter_enable    <= 1'b1;
         cfg_ff.max_counter       <= MAX_COUNTER_RESET;
         cfg_ff.freshness_enable  <= 1'b0;
         cfg_ff.freshness_timeout <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/ecfc_ctrl.sv =====
// ecfc_ctrl: sequencer for table clearing and the per-request read, evaluate, commit
// depends on ecfc_pkg
`default_nettype none

module ecfc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire ecfc_pkg::dp_status_type dp_status,
   output ecfc_pkg::ctrl_cmd_type       cmd
);
   import ecfc_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           commit;

   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (dp_status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: state_in = ST_DONE;
         ST_DONE: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_READ: cmd.mem_read = 1'b1;
         ST_EVAL: cmd.eval = 1'b1;
         ST_DONE: cmd.commit = commit;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/ecfc_datapath.sv =====
// ecfc_datapath: request registers, counter table memory, check logic and result registers
// depends on ecfc_pkg, driven by ecfc_ctrl commands
`default_nettype none

module ecfc_datapath #(
   parameter int unsigned ID_ENTRIES = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ecfc_pkg::ctrl_cmd_type           cmd,
   output ecfc_pkg::dp_status_type               dp_status,
   input  wire ecfc_pkg::cfg_type                cfg,
   input  wire logic                             req_func,
   input  wire logic [ecfc_pkg::DATA_ID_W-1:0]   req_data_id,
   input  wire logic                             req_has_header,
   input  wire logic [ecfc_pkg::RX_ID_W-1:0]     req_received_data_id,
   input  wire logic [ecfc_pkg::CRC_W-1:0]       req_rx_crc,
   input  wire logic [ecfc_pkg::CRC_W-1:0]       req_computed_crc,
   input  wire logic [ecfc_pkg::CNT_W-1:0]       req_received_counter,
   input  wire logic [ecfc_pkg::FRESH_W-1:0]     req_received_freshness,
   input  wire logic [ecfc_pkg::FRESH_W-1:0]     req_now_ms,
   output ecfc_pkg::status_type                  rsp_status,
   output logic [ecfc_pkg::CRC_W-1:0]            rsp_header_crc,
   output logic [ecfc_pkg::CNT_W-1:0]            rsp_header_counter,
   output logic [ecfc_pkg::FRESH_W-1:0]          rsp_header_freshness
);
   import ecfc_pkg::*;

   localparam int unsigned AW = $clog2(ID_ENTRIES);

   // data id to table entry
   logic [AW-1:0] idx_lut [ID_SPAN];

   for (genvar g = 0; g < ID_SPAN; g++) begin : g_idx
      localparam int unsigned IDX_VAL = g % ID_ENTRIES;
      assign idx_lut[g] = AW'(IDX_VAL);
   end

   // request registers
   logic                 func_ff;
   logic [DATA_ID_W-1:0] data_id_ff;
   logic                 has_header_ff;
   logic [RX_ID_W-1:0]   rx_id_ff;
   logic [CRC_W-1:0]     rx_crc_ff;
   logic [CRC_W-1:0]     calc_crc_ff;
   logic [CNT_W-1:0]     rx_cnt_ff;
   logic [FRESH_W-1:0]   rx_fresh_ff;
   logic [FRESH_W-1:0]   now_ff;
   logic [AW-1:0]        idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff       <= req_func;
         data_id_ff    <= req_data_id;
         has_header_ff <= req_has_header;
         rx_id_ff      <= req_received_data_id;
         rx_crc_ff     <= req_rx_crc;
         calc_crc_ff   <= req_computed_crc;
         rx_cnt_ff     <= req_received_counter;
         rx_fresh_ff   <= req_received_freshness;
         now_ff        <= req_now_ms;
         idx_ff        <= idx_lut[req_data_id];
      end
   end

   // clearing pass address
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;

   assign clr_addr_in = cmd.clear_wr ? clr_addr_ff + AW'(1) : clr_addr_ff;
   assign dp_status.clear_last = (clr_addr_ff == AW'(ID_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // counter table
   logic [CNT_W-1:0] table_mem [ID_ENTRIES];
   logic [CNT_W-1:0] last_ff;
   logic             wr_en_ff;
   logic [CNT_W-1:0] wr_data_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [CNT_W-1:0] mem_wdata;

   assign mem_we    = cmd.clear_wr || (cmd.commit && wr_en_ff);
   assign mem_waddr = cmd.clear_wr ? clr_addr_ff : idx_ff;
   assign mem_wdata = cmd.clear_wr ? '0 : wr_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_waddr] <= mem_wdata;
      if (cmd.mem_read) last_ff <= table_mem[idx_ff];
   end

   // check logic
   logic [CRC_W-1:0]   crc_mask;
   logic               pre_bad;
   logic               near_top;
   logic               in_window;
   logic               cnt_bad;
   logic               cnt_upd;
   logic [FRESH_W-1:0] age;
   logic               stale;
   logic [CNT_W-1:0]   next_cnt;
   status_type         res_status_in;
   logic [CRC_W-1:0]   res_crc_in;
   logic [CNT_W-1:0]   res_cnt_in;
   logic [FRESH_W-1:0] res_fresh_in;
   logic               wr_en_in;
   logic [CNT_W-1:0]   wr_data_in;

   always_comb begin
      case (cfg.crc_width_mode)
         CRC_MODE_8:  crc_mask = CRC_MASK_8;
         CRC_MODE_16: crc_mask = CRC_MASK_16;
         default:     crc_mask = '1;
      endcase
   end

   always_comb begin
      pre_bad = !has_header_ff
             || (rx_id_ff != {{(RX_ID_W - DATA_ID_W){1'b0}}, data_id_ff})
             || (cfg.crc_enable && (((rx_crc_ff ^ calc_crc_ff) & crc_mask) != '0));
      near_top  = (cfg.max_counter >= ROLL_WINDOW)
               && (last_ff > (cfg.max_counter - ROLL_WINDOW));
      in_window = (rx_cnt_ff != '0) && (rx_cnt_ff <= ROLL_WINDOW);
      if (!cfg.counter_enable) begin
         cnt_bad = 1'b0;
      end else if (last_ff == '0) begin
         cnt_bad = (rx_cnt_ff == '0) || (rx_cnt_ff > cfg.max_counter);
      end else begin
         cnt_bad = (rx_cnt_ff < last_ff) && !(near_top && in_window);
      end
      cnt_upd = (rx_cnt_ff > last_ff) || (near_top && (rx_cnt_ff <= ROLL_WINDOW));
      age     = now_ff - rx_fresh_ff;
      stale   = cfg.freshness_enable && (age > cfg.freshness_timeout)
             && (age < (FRESH_ALL_ONE - cfg.freshness_timeout));
      next_cnt = (last_ff >= cfg.max_counter) ? COUNTER_ONE : last_ff + COUNTER_ONE;
   end

   always_comb begin
      res_status_in = STATUS_OK;
      res_crc_in    = '0;
      res_cnt_in    = '0;
      res_fresh_in  = '0;
      wr_en_in      = 1'b0;
      wr_data_in    = rx_cnt_ff;
      if (func_ff == FUNC_PROTECT) begin
         if (cfg.crc_enable) res_crc_in = calc_crc_ff;
         if (cfg.counter_enable) begin
            res_cnt_in = next_cnt;
            wr_en_in   = 1'b1;
            wr_data_in = next_cnt;
         end
         if (cfg.freshness_enable) res_fresh_in = now_ff;
      end else begin
         if (pre_bad || cnt_bad) begin
            res_status_in = STATUS_INVALID;
         end else begin
            wr_en_in = cfg.counter_enable && cnt_upd;
            if (stale) res_status_in = STATUS_STALE;
         end
      end
   end

   // evaluated result
   status_type         res_status_ff;
   logic [CRC_W-1:0]   res_crc_ff;
   logic [CNT_W-1:0]   res_cnt_ff;
   logic [FRESH_W-1:0] res_fresh_ff;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         res_status_ff <= res_status_in;
         res_crc_ff    <= res_crc_in;
         res_cnt_ff    <= res_cnt_in;
         res_fresh_ff  <= res_fresh_in;
         wr_en_ff      <= wr_en_in;
         wr_data_ff    <= wr_data_in;
      end
   end

   // response output registers
   status_type         rsp_status_ff;
   logic [CRC_W-1:0]   rsp_crc_ff;
   logic [CNT_W-1:0]   rsp_cnt_ff;
   logic [FRESH_W-1:0] rsp_fresh_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= res_status_ff;
         rsp_crc_ff    <= res_crc_ff;
         rsp_cnt_ff    <= res_cnt_ff;
         rsp_fresh_ff  <= res_fresh_ff;
      end
   end

   assign rsp_status           = rsp_status_ff;
   assign rsp_header_crc       = rsp_crc_ff;
   assign rsp_header_counter   = rsp_cnt_ff;
   assign rsp_header_freshness = rsp_fresh_ff;

endmodule

`default_nettype wire

// ===== sv/e2e_counter_freshness_checker_unit.sv =====
// e2e_counter_freshness_checker_unit: top level of the e2e protection counter and freshness checker
// depends on ecfc_pkg, ecfc_csr, ecfc_ctrl and ecfc_datapath
//
// Requests are taken one at a time, each passing through the accept cycle, the read of the
// counter table entry, evaluation, then commit of the response and the table write-back. The
// next request is not accepted before the last is committed: the read-modify-write of the
// counter table serves one request at a time. A response waiting in the output register does
// not hold off the next request; only its commit waits for the response to be taken. After
// reset the counter table is cleared one entry per cycle with req_ready low; configuration
// writes are taken throughout.
// The table entry is data_id modulo ID_ENTRIES.
`default_nettype none

module e2e_counter_freshness_checker_unit #(
   parameter int unsigned ID_ENTRIES = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire ecfc_pkg::csr_index_type         csr_index,
   input  wire logic [ecfc_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_func,
   input  wire logic [ecfc_pkg::DATA_ID_W-1:0]  req_data_id,
   input  wire logic                            req_has_header,
   input  wire logic [ecfc_pkg::RX_ID_W-1:0]    req_received_data_id,
   input  wire logic [ecfc_pkg::CRC_W-1:0]      req_rx_crc,
   input  wire logic [ecfc_pkg::CRC_W-1:0]      req_computed_crc,
   input  wire logic [ecfc_pkg::CNT_W-1:0]      req_received_counter,
   input  wire logic [ecfc_pkg::FRESH_W-1:0]    req_received_freshness,
   input  wire logic [ecfc_pkg::FRESH_W-1:0]    req_now_ms,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output ecfc_pkg::status_type                 rsp_status,
   output logic [ecfc_pkg::CRC_W-1:0]           rsp_header_crc,
   output logic [ecfc_pkg::CNT_W-1:0]           rsp_header_counter,
   output logic [ecfc_pkg::FRESH_W-1:0]         rsp_header_freshness
);
   import ecfc_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   ecfc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ecfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   ecfc_datapath #(
      .ID_ENTRIES (ID_ENTRIES)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .dp_status              (dp_status),
      .cfg                    (cfg),
      .req_func               (req_func),
      .req_data_id            (req_data_id),
      .req_has_header         (req_has_header),
      .req_received_data_id   (req_received_data_id),
      .req_rx_crc             (req_rx_crc),
      .req_computed_crc       (req_computed_crc),
      .req_received_counter   (req_received_counter),
      .req_received_freshness (req_received_freshness),
      .req_now_ms             (req_now_ms),
      .rsp_status             (rsp_status),
      .rsp_header_crc         (rsp_header_crc),
      .rsp_header_counter     (rsp_header_counter),
      .rsp_header_freshness   (rsp_header_freshness)
   );

endmodule

`default_nettype wire
